// ===== rtl/core/dstwr_pkg.sv =====
// ----------------------------------------------------------------------------
// ds-twr responder package
// shared codes and constants for the ranging responder
// ----------------------------------------------------------------------------
`default_nettype none
package dstwr_pkg;
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_TXDONE  = 2'd1;
  localparam logic [1:0] MODE_RX      = 2'd2;
  localparam logic [1:0] MODE_REFUSED = 2'd3;

  localparam logic [1:0] ACT_SYNC  = 2'd0;
  localparam logic [1:0] ACT_RESP  = 2'd1;
  localparam logic [1:0] ACT_RANGE = 2'd2;
  localparam logic [1:0] ACT_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT = 3'd1;
  localparam logic [2:0] ERR_LENGTH  = 3'd2;
  localparam logic [2:0] ERR_STS     = 3'd3;
  localparam logic [2:0] ERR_CODE    = 3'd4;
  localparam logic [2:0] ERR_SEQ     = 3'd5;
  localparam logic [2:0] ERR_REFUSED = 3'd6;

  localparam logic [2:0] REG_REPLY_DELAY  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT      = 3'd1;
  localparam logic [2:0] REG_POLL_LENGTH  = 3'd2;
  localparam logic [2:0] REG_FINAL_LENGTH = 3'd3;
  localparam logic [2:0] REG_POLL_CODE    = 3'd4;
  localparam logic [2:0] REG_FINAL_CODE   = 3'd5;

  localparam logic [1:0] PH_SYNC  = 2'd0;
  localparam logic [1:0] PH_POLL  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  localparam logic [31:0] RANGE_SCALE = 32'd19647198;
endpackage
`default_nettype wire

// ===== rtl/core/ds_twr_ranging_responder_unit.sv =====
// ----------------------------------------------------------------------------
// ds-twr ranging responder
// tag side of an asymmetric double-sided two-way ranging exchange
// ----------------------------------------------------------------------------
// sync and error results are registered straight to the output; the delayed
//   response passes through S_MUL first. a range result takes a difference step
//   and 8 product steps on one shared 32x32 multiplier, then 128 restoring division
//   steps on one shared 65-bit subtractor, one bit a cycle (fewer on early saturation).
// throughput: one event at a time; in_ready drops until the result is taken.
// reset: asynchronous active low; control registers load their documented values, datapath registers are not reset.
`default_nettype none
module ds_twr_ranging_responder_unit
  import dstwr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [39:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [6:0]  frame_length_i,
  input  wire logic        sts_good_i,
  input  wire logic [7:0]  function_code_i,
  input  wire logic [7:0]  seq_in_i,
  input  wire logic [39:0] event_time_i,
  input  wire logic [39:0] remote_round_i,
  input  wire logic [39:0] remote_reply_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       action_o,
  output logic [7:0]       seq_out_o,
  output logic [31:0]      tx_time_o,
  output logic [2:0]       error_code_o,
  output logic [31:0]      distance_mm_o,
  output logic [63:0]      local_reply_o,
  output logic [63:0]      local_round_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [39:0] reply_delay_q;
  logic [15:0] timeout_q;
  logic [6:0]  poll_len_q, final_len_q;
  logic [7:0]  poll_code_q, final_code_q;

  logic [1:0]  phase_q;
  logic [7:0]  next_seq_q;
  logic        tx_seen_q, rx_acc_q;
  logic [39:0] poll_t_q, resp_t_q, final_t_q, hround_q, hreply_q;
  logic [15:0] ticks_q;

  logic [2:0]  st_q;
  logic [3:0]  mstep_q;
  logic [6:0]  dcnt_q;
  logic [63:0] treply_q, tround_q;
  logic [63:0] s_q, den_q, rem_q;
  logic [127:0] num_q;
  logic [31:0] quo_q;

  logic [1:0]  act_q;
  logic [7:0]  seqo_q;
  logic [31:0] txt_q, dist_q;
  logic [2:0]  err_q;

  assign cfg_ready_o   = (st_q == S_IDLE);
  assign in_ready_o    = (st_q == S_IDLE);
  assign out_valid_o   = (st_q == S_OUT);
  assign action_o      = act_q;
  assign seq_out_o     = seqo_q;
  assign tx_time_o     = txt_q;
  assign error_code_o  = err_q;
  assign distance_mm_o = dist_q;
  assign local_reply_o = (act_q == ACT_RANGE) ? treply_q : 64'd0;
  assign local_round_o = (act_q == ACT_RANGE) ? tround_q : 64'd0;

  // event decode
  logic        in_fire, fw, frame_ok;
  logic [2:0]  ferr;
  logic [15:0] ticks_inc;
  always_comb begin
    in_fire   = in_valid_i && in_ready_o;
    fw        = (phase_q == PH_FINAL);
    ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
    priority if (frame_length_i != (fw ? final_len_q : poll_len_q)) ferr = ERR_LENGTH;
    else if (!sts_good_i) ferr = ERR_STS;
    else if (function_code_i != (fw ? final_code_q : poll_code_q)) ferr = ERR_CODE;
    else if (seq_in_i != next_seq_q) ferr = ERR_SEQ;
    else ferr = ERR_NONE;
    frame_ok = (ferr == ERR_NONE);
  end

  logic [64:0] rsh;
  logic [64:0] rdiff;
  always_comb begin
    rsh   = {rem_q, num_q[127]};
    rdiff = rsh - {1'b0, den_q};
  end

  logic [39:0] delay_sum;
  assign delay_sum = poll_t_q + reply_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_delay_q <= 40'd6389800000;
      timeout_q     <= 16'd1000;
      poll_len_q    <= 7'd12;
      final_len_q   <= 7'd22;
      poll_code_q   <= 8'h21;
      final_code_q  <= 8'h23;
      phase_q  <= PH_SYNC;
      next_seq_q <= '0;
      tx_seen_q <= 1'b0;
      rx_acc_q  <= 1'b0;
      poll_t_q <= '0; resp_t_q <= '0; final_t_q <= '0;
      hround_q <= '0; hreply_q <= '0;
      ticks_q  <= '0;
      st_q     <= S_IDLE;
      mstep_q  <= '0;
      dcnt_q   <= '0;
      act_q <= '0; seqo_q <= '0; txt_q <= '0; err_q <= '0; dist_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_REPLY_DELAY:  reply_delay_q <= cfg_data_i;
          REG_TIMEOUT:      timeout_q     <= cfg_data_i[15:0];
          REG_POLL_LENGTH:  poll_len_q    <= cfg_data_i[6:0];
          REG_FINAL_LENGTH: final_len_q   <= cfg_data_i[6:0];
          REG_POLL_CODE:    poll_code_q   <= cfg_data_i[7:0];
          REG_FINAL_CODE:   final_code_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q <= ACT_ERROR; seqo_q <= '0; txt_q <= '0; dist_q <= '0;
            err_q <= ERR_NONE;
            if (phase_q != PH_POLL && phase_q != PH_FINAL) begin
              act_q <= ACT_SYNC; seqo_q <= next_seq_q;
              next_seq_q <= next_seq_q + 8'd1;
              ticks_q <= '0; tx_seen_q <= 1'b0; rx_acc_q <= 1'b0;
              phase_q <= PH_POLL; st_q <= S_OUT;
            end else if (mode_i == MODE_TICK) begin
              ticks_q <= ticks_inc;
              if (ticks_inc > timeout_q) begin
                phase_q <= PH_SYNC; tx_seen_q <= 1'b0; rx_acc_q <= 1'b0;
                poll_t_q <= '0; resp_t_q <= '0; final_t_q <= '0;
                err_q <= ERR_TIMEOUT; st_q <= S_OUT;
              end
            end else if (mode_i == MODE_REFUSED) begin
              phase_q <= PH_SYNC; tx_seen_q <= 1'b0; rx_acc_q <= 1'b0;
              err_q <= ERR_REFUSED; st_q <= S_OUT;
            end else if (mode_i == MODE_RX && !frame_ok) begin
              phase_q <= PH_SYNC; tx_seen_q <= 1'b0; rx_acc_q <= 1'b0;
              err_q <= ferr; st_q <= S_OUT;
            end else begin
              if (mode_i == MODE_TXDONE) begin
                tx_seen_q <= 1'b1;
                if (fw) resp_t_q <= event_time_i;
              end else begin
                if (fw) begin
                  final_t_q <= event_time_i;
                  hround_q <= remote_round_i; hreply_q <= remote_reply_i;
                end else poll_t_q <= event_time_i;
                next_seq_q <= next_seq_q + 8'd1;
                rx_acc_q <= 1'b1;
              end
              // once transmit-done and a good frame have both been seen, move on to S_MUL
              if ((tx_seen_q || mode_i == MODE_TXDONE) &&
                  (rx_acc_q || mode_i == MODE_RX)) begin
                st_q <= S_MUL; mstep_q <= '0;
                dcnt_q <= 7'd127;
              end
            end
          end
        end
        S_MUL: begin
          if (phase_q == PH_POLL) begin
            act_q <= ACT_RESP; seqo_q <= next_seq_q;
            txt_q <= delay_sum[39:8] ;
            next_seq_q <= next_seq_q + 8'd1;
            tx_seen_q <= 1'b0; rx_acc_q <= 1'b0;
            phase_q <= PH_FINAL; st_q <= S_OUT;
          end else begin
            mstep_q <= mstep_q + 4'd1;
            if (mstep_q == 4'd8) begin
              act_q <= ACT_RANGE;
              phase_q <= PH_SYNC; tx_seen_q <= 1'b0; rx_acc_q <= 1'b0;
              if (den_q == 64'd0) begin
                dist_q <= 32'hFFFF_FFFF; st_q <= S_OUT;
              end else st_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q - 7'd1;
          if (!(rdiff[64] == 1'b1 && rsh[64] == 1'b0) && dcnt_q >= 7'd32) begin
            dist_q <= 32'hFFFF_FFFF; st_q <= S_OUT;
          end else if (dcnt_q == 7'd0) begin
            dist_q <= (rsh[64] || !rdiff[64]) ? (quo_q << 1) | 32'd1 : (quo_q << 1);
            st_q <= S_OUT;
          end
        end
        default: begin
          if (out_ready_i) st_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE) begin
      quo_q <= '0;
      rem_q <= '0;
      treply_q <= '0;
      tround_q <= '0;
    end
    if (st_q == S_MUL && phase_q == PH_FINAL && mstep_q == 4'd0) begin
      // times are settled now; form differences in the first step
      treply_q <= {24'd0, resp_t_q} - {24'd0, poll_t_q};
      tround_q <= {24'd0, final_t_q} - {24'd0, resp_t_q};
    end
    if (st_q == S_DIV) begin
      rem_q <= (rsh[64] || !rdiff[64]) ? rdiff[63:0] : rsh[63:0];
      quo_q <= (rsh[64] || !rdiff[64]) ? (quo_q << 1) | 32'd1 : (quo_q << 1);
    end
  end

  // multiply sequence: step 0 computes differences, steps 1..8 use the multiplier
  logic [63:0] mp;
  logic [31:0] ma, mb;
  always_comb begin
    unique case (mstep_q)
      4'd2: begin ma = {24'd0, hround_q[39:32]}; mb = tround_q[31:0]; end
      4'd3: begin ma = hround_q[31:0]; mb = tround_q[63:32]; end
      4'd4: begin ma = treply_q[31:0]; mb = hreply_q[31:0]; end
      4'd5: begin ma = treply_q[63:32]; mb = hreply_q[31:0]; end
      4'd6: begin ma = treply_q[31:0]; mb = {24'd0, hreply_q[39:32]}; end
      4'd7: begin ma = s_q[31:0]; mb = RANGE_SCALE; end
      4'd8: begin ma = s_q[63:32]; mb = RANGE_SCALE; end
      default: begin ma = hround_q[31:0]; mb = tround_q[31:0]; end
    endcase
  end
  assign mp = ma * mb;

  always_ff @(posedge clk_i) begin
    if (st_q == S_MUL && phase_q == PH_FINAL) begin
      unique case (mstep_q)
        4'd1: begin
          s_q   <= mp;
          den_q <= ({24'd0, hround_q} + tround_q + treply_q + {24'd0, hreply_q}) << 22;
        end
        4'd2: s_q <= s_q + {mp[31:0], 32'd0};
        4'd3: s_q <= s_q + {mp[31:0], 32'd0};
        4'd4: s_q <= s_q - mp;
        4'd5: s_q <= s_q - {mp[31:0], 32'd0};
        4'd6: s_q <= s_q - {mp[31:0], 32'd0};
        4'd7: num_q <= {64'd0, mp};
        4'd8: num_q <= num_q + {32'd0, mp, 32'd0};
        default: ;
      endcase
    end else if (st_q == S_DIV) begin
      num_q <= num_q << 1;
    end
  end

  property p_busy_no_ready;
    @(posedge clk_i) disable iff (!rst_ni) (st_q == S_DIV) |-> !in_ready_o;
  endproperty
  a_busy_no_ready: assert property (p_busy_no_ready)
    else $error("ready high during division");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(dist_q)))
    else $error("result changed while stalled");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && act_q == ACT_ERROR) |-> (err_q != ERR_NONE))
    else $error("error result without code");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ds-twr responder testbench
// drives radio events into the responder under random handshake gaps and
// checks every emitted action against an in-bench model of the exchange
// ----------------------------------------------------------------------------
module testbench;
  import dstwr_pkg::*;

  typedef struct packed {
    logic [39:0] delay;
    logic [15:0] tmo;
    logic [6:0]  plen;
    logic [6:0]  flen;
    logic [7:0]  pcode;
    logic [7:0]  fcode;
  } regs_t;

  typedef struct packed {
    logic [1:0]  ph;
    logic [7:0]  seq;
    logic        tx;
    logic        rx;
    logic [39:0] t_poll;
    logic [39:0] t_resp;
    logic [39:0] t_final;
    logic [39:0] h_round;
    logic [39:0] h_reply;
    logic [15:0] ticks;
  } xchg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  flen;
    logic        sts;
    logic [7:0]  code;
    logic [7:0]  seq;
    logic [39:0] etime;
    logic [39:0] rround;
    logic [39:0] rreply;
  } event_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  seq;
    logic [31:0] txt;
    logic [2:0]  err;
    logic [31:0] dmm;
    logic [63:0] rep;
    logic [63:0] rnd;
  } action_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [39:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [1:0] mode_i = '0;
  logic [6:0] frame_length_i = '0;
  logic sts_good_i = 1'b0;
  logic [7:0] function_code_i = '0;
  logic [7:0] seq_in_i = '0;
  logic [39:0] event_time_i = '0;
  logic [39:0] remote_round_i = '0;
  logic [39:0] remote_reply_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o, in_ready_o, out_valid_o;
  logic [1:0] action_o;
  logic [7:0] seq_out_o;
  logic [31:0] tx_time_o;
  logic [2:0] error_code_o;
  logic [31:0] distance_mm_o;
  logic [63:0] local_reply_o, local_round_o;

  ds_twr_ranging_responder_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  regs_t   regs;
  xchg_t   plan_st, live_st;
  event_t  event_q[$];
  action_t action_q[$];
  event_t  cur_ev;
  bit      in_busy = 0, in_taken = 0, rx_stall = 0;
  int      send_idle_pct = 0, recv_idle_pct = 0;
  int      errors = 0, n_events = 0, n_actions = 0, n_range = 0, n_err = 0, n_sat = 0;

  // one step of the exchange: returns 1 when an action is emitted
  function automatic bit exchange_step(inout xchg_t s, input regs_t c, input event_t e,
                                       output action_t r);
    logic [63:0] rep, rnd, num_s, den;
    logic [127:0] quo;
    logic [40:0] when;
    logic [2:0] err;
    bit fw;
    r = '0;
    if (s.ph != PH_POLL && s.ph != PH_FINAL) begin
      r.act = ACT_SYNC;
      r.seq = s.seq;
      s.seq = s.seq + 8'd1;
      s.ticks = '0;
      s.tx = 0;
      s.rx = 0;
      s.ph = PH_POLL;
      return 1;
    end
    fw = (s.ph == PH_FINAL);
    if (e.mode == MODE_TICK) begin
      if (s.ticks != 16'hFFFF) s.ticks = s.ticks + 16'd1;
      if (s.ticks > c.tmo) begin
        s.ph = PH_SYNC;
        s.tx = 0;
        s.rx = 0;
        s.t_poll = '0;
        s.t_resp = '0;
        s.t_final = '0;
        r.act = ACT_ERROR;
        r.err = ERR_TIMEOUT;
        return 1;
      end
      return 0;
    end
    if (e.mode == MODE_REFUSED) begin
      s.ph = PH_SYNC;
      s.tx = 0;
      s.rx = 0;
      r.act = ACT_ERROR;
      r.err = ERR_REFUSED;
      return 1;
    end
    if (e.mode == MODE_TXDONE) begin
      s.tx = 1;
      if (fw) s.t_resp = e.etime;
    end else begin
      err = ERR_NONE;
      if (e.flen != (fw ? c.flen : c.plen)) err = ERR_LENGTH;
      else if (!e.sts) err = ERR_STS;
      else if (e.code != (fw ? c.fcode : c.pcode)) err = ERR_CODE;
      else if (e.seq != s.seq) err = ERR_SEQ;
      if (err != ERR_NONE) begin
        s.ph = PH_SYNC;
        s.tx = 0;
        s.rx = 0;
        r.act = ACT_ERROR;
        r.err = err;
        return 1;
      end
      if (fw) begin
        s.t_final = e.etime;
        s.h_round = e.rround;
        s.h_reply = e.rreply;
      end else begin
        s.t_poll = e.etime;
      end
      s.seq = s.seq + 8'd1;
      s.rx = 1;
    end
    if (!(s.tx && s.rx)) return 0;
    if (!fw) begin
      when = {1'b0, s.t_poll} + {1'b0, c.delay};
      r.act = ACT_RESP;
      r.seq = s.seq;
      r.txt = when[39:8];
      s.seq = s.seq + 8'd1;
      s.tx = 0;
      s.rx = 0;
      s.ph = PH_FINAL;
      return 1;
    end
    rep = {24'b0, s.t_resp} - {24'b0, s.t_poll};
    rnd = {24'b0, s.t_final} - {24'b0, s.t_resp};
    num_s = {24'b0, s.h_round} * rnd - rep * {24'b0, s.h_reply};
    den = ({24'b0, s.h_round} + rnd + rep + {24'b0, s.h_reply}) << 22;
    r.act = ACT_RANGE;
    r.rep = rep;
    r.rnd = rnd;
    if (den == 64'd0) begin
      r.dmm = 32'hFFFF_FFFF;
    end else begin
      quo = ({64'b0, num_s} * 128'd19647198) / {64'b0, den};
      r.dmm = (quo[127:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
    end
    s.ph = PH_SYNC;
    s.tx = 0;
    s.rx = 0;
    return 1;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (in_taken) begin
      in_busy = 0;
      in_taken = 0;
    end
    if (!in_busy && rst_ni && event_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
    begin
      cur_ev = event_q.pop_front();
      in_busy = 1;
    end
    in_valid_i = in_busy;
    {mode_i, frame_length_i, sts_good_i, function_code_i, seq_in_i,
     event_time_i, remote_round_i, remote_reply_i} = cur_ev;
    out_ready_i = !rx_stall && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // request acceptance and result monitor
  always @(posedge clk_i) begin
    action_t r, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_taken = 1;
      n_events++;
      if (exchange_step(live_st, regs, cur_ev, r)) action_q.push_back(r);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_actions++;
      if (action_q.size() == 0) begin
        report("unexpected action", {62'b0, action_o}, 64'd0);
      end else begin
        want = action_q.pop_front();
        if (action_o != want.act) report("action", 64'(action_o), 64'(want.act));
        if (seq_out_o != want.seq) report("seq_out", 64'(seq_out_o), 64'(want.seq));
        if (tx_time_o != want.txt) report("tx_time", 64'(tx_time_o), 64'(want.txt));
        if (error_code_o != want.err)
          report("error_code", 64'(error_code_o), 64'(want.err));
        if (distance_mm_o != want.dmm)
          report("distance_mm", 64'(distance_mm_o), 64'(want.dmm));
        if (local_reply_o != want.rep) report("local_reply", local_reply_o, want.rep);
        if (local_round_o != want.rnd) report("local_round", local_round_o, want.rnd);
        if (want.act == ACT_RANGE) n_range++;
        if (want.act == ACT_ERROR) n_err++;
        if (want.act == ACT_RANGE && want.dmm == 32'hFFFF_FFFF) n_sat++;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [39:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_REPLY_DELAY:  regs.delay = val;
      REG_TIMEOUT:      regs.tmo = val[15:0];
      REG_POLL_LENGTH:  regs.plen = val[6:0];
      REG_FINAL_LENGTH: regs.flen = val[6:0];
      REG_POLL_CODE:    regs.pcode = val[7:0];
      REG_FINAL_CODE:   regs.fcode = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_regs(input regs_t c);
    reg_write(REG_REPLY_DELAY, c.delay);
    reg_write(REG_TIMEOUT, {24'b0, c.tmo});
    reg_write(REG_POLL_LENGTH, {33'b0, c.plen});
    reg_write(REG_FINAL_LENGTH, {33'b0, c.flen});
    reg_write(REG_POLL_CODE, {32'b0, c.pcode});
    reg_write(REG_FINAL_CODE, {32'b0, c.fcode});
  endtask

  function automatic logic [39:0] rand40();
    return 40'({$urandom(), $urandom()});
  endfunction

  function automatic event_t rand_event();
    event_t e;
    e = 146'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    return e;
  endfunction

  task automatic queue_event(input event_t e);
    action_t r;
    void'(exchange_step(plan_st, regs, e, r));
    event_q.push_back(e);
  endtask

  function automatic event_t good_frame(input bit fw, input logic [39:0] t,
                                        input logic [39:0] rr, input logic [39:0] rp);
    event_t e;
    e = rand_event();
    e.mode = MODE_RX;
    e.flen = fw ? regs.flen : regs.plen;
    e.sts = 1'b1;
    e.code = fw ? regs.fcode : regs.pcode;
    e.seq = plan_st.seq;
    e.etime = t;
    e.rround = rr;
    e.rreply = rp;
    return e;
  endfunction

  function automatic event_t mk_event(input logic [1:0] m, input logic [39:0] t);
    event_t e;
    e = rand_event();
    e.mode = m;
    e.etime = t;
    return e;
  endfunction

  // one half of the exchange: transmit-done plus received frame, sometimes broken
  task automatic run_stage(input bit fw, input logic [39:0] tx_t, input logic [39:0] rx_t,
                           input logic [39:0] rr, input logic [39:0] rp);
    event_t tx, rx;
    int f;
    tx = mk_event(MODE_TXDONE, tx_t);
    rx = good_frame(fw, rx_t, rr, rp);
    f = $urandom_range(0, 39);
    case (f)
      0: rx.flen = rx.flen + 7'd1;
      1: rx.sts = 1'b0;
      2: rx.code = rx.code ^ (8'd1 << $urandom_range(0, 7));
      3: rx.seq = rx.seq + 8'd1 + 8'($urandom_range(0, 254));
      4: tx.mode = MODE_REFUSED;
      5: queue_event(rand_event());
      default: ;
    endcase
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
      queue_event(mk_event(MODE_TICK, rand40()));
    if ($urandom_range(0, 1)) begin
      queue_event(tx);
      if (f == 6) queue_event(tx);
      queue_event(rx);
    end else begin
      queue_event(rx);
      if (f == 7) begin
        // a repeated frame has to carry the advanced sequence number
        rx.seq = plan_st.seq;
        rx.etime = rx.etime + 40'd3;
        queue_event(rx);
      end
      queue_event(tx);
    end
  endtask

  task automatic run_exchange();
    logic [39:0] tp, tr, tf, tof;
    if (plan_st.ph != PH_POLL && plan_st.ph != PH_FINAL) queue_event(rand_event());
    tp = rand40();
    tr = tp + 40'($urandom_range(0, 32'h7FFF_FFFF));
    tf = tr + 40'($urandom_range(0, 32'h7FFF_FFFF));
    tof = 40'($urandom_range(0, 100000));
    run_stage(0, rand40(), tp, rand40(), rand40());
    if (plan_st.ph != PH_FINAL) return;
    if ($urandom_range(0, 3) == 0)
      run_stage(1, rand40(), rand40(), rand40(), rand40());
    else
      run_stage(1, tr, tf, (tr - tp) + 2 * tof, (tf - tr) - 2 * tof);
  endtask

  task automatic drain();
    while (event_q.size() > 0 || in_busy || action_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_run(input int count);
    int goal;
    goal = n_events + event_q.size() + count;
    while (n_events + event_q.size() < goal) run_exchange();
    drain();
  endtask

  initial begin
    regs_t rc;
    event_t e;
    regs = '{delay: 40'd6389800000, tmo: 16'd1000, plen: 7'd12, flen: 7'd22,
             pcode: 8'h21, fcode: 8'h23};
    plan_st = '0;
    live_st = '0;
    cur_ev = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: timeout, refused, each frame check, zero divisor, extremes
    reg_write(REG_TIMEOUT, 40'd3);
    repeat (5) queue_event(mk_event(MODE_TICK, '0));
    queue_event(mk_event(MODE_REFUSED, '0));
    queue_event(mk_event(MODE_REFUSED, '0));
    queue_event(mk_event(MODE_TICK, '0));
    e = good_frame(0, '0, '0, '0); e.flen = '0; queue_event(e);
    queue_event(mk_event(MODE_TXDONE, '0));
    e = good_frame(0, '0, '0, '0); e.sts = 1'b0; queue_event(e);
    queue_event(mk_event(MODE_TICK, '0));
    e = good_frame(0, '0, '0, '0); e.code = 8'hFF; queue_event(e);
    queue_event(mk_event(MODE_TICK, '0));
    e = good_frame(0, '0, '0, '0); e.seq = ~e.seq; queue_event(e);
    // every time equal and remote times zero: divisor is zero
    queue_event(mk_event(MODE_TICK, '0));
    queue_event(mk_event(MODE_TXDONE, 40'd77));
    queue_event(good_frame(0, 40'd77, '0, '0));
    queue_event(mk_event(MODE_TXDONE, 40'd77));
    queue_event(good_frame(1, 40'd77, '0, '0));
    queue_event(mk_event(MODE_TICK, '0));
    queue_event(good_frame(0, '1, '1, '1));
    queue_event(mk_event(MODE_TXDONE, '1));
    queue_event(mk_event(MODE_TXDONE, '0));
    queue_event(good_frame(1, '1, '1, '1));
    drain();

    send_idle_pct = 15;
    recv_idle_pct = 76;
    load_regs('{delay: '1, tmo: 16'hFFFF, plen: 7'd127, flen: 7'd0, pcode: 8'hFF, fcode: 8'h00});
    repeat (40) run_exchange();
    // receiver holds off while requests keep coming
    fork
      begin
        @(negedge clk_i);
        rx_stall = 1;
        repeat (400) @(negedge clk_i);
        rx_stall = 0;
      end
    join_none
    random_run(240);
    load_regs('{delay: '0, tmo: 16'd1, plen: 7'd0, flen: 7'd127, pcode: 8'h00, fcode: 8'hFF});
    random_run(240);

    send_idle_pct = 76;
    recv_idle_pct = 15;
    load_regs('{delay: 40'd6389800000, tmo: 16'd20, plen: 7'd12, flen: 7'd22,
                pcode: 8'h21, fcode: 8'h23});
    random_run(240);
    rc = '{delay: rand40(), tmo: 16'($urandom_range(2, 65535)), plen: 7'($urandom()),
           flen: 7'($urandom()), pcode: 8'($urandom()), fcode: 8'($urandom())};
    load_regs(rc);
    random_run(240);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs('{delay: 40'd6389800000, tmo: 16'd1000, plen: 7'd12, flen: 7'd22,
                pcode: 8'h21, fcode: 8'h23});
    random_run(240);

    $display("covered %0d events and %0d actions: %0d ranges (%0d saturated), %0d errors",
             n_events, n_actions, n_range, n_sat, n_err);
    $display("register sets included all-zero and all-ones extremes");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/dstwr_pkg.sv
rtl/core/ds_twr_ranging_responder_unit.sv
tb/testbench.sv
